FILE: rtl/header_text_tokenizer_macros.svh
// assertion macros used by the tokenizer lexer
`ifndef HEADER_TEXT_TOKENIZER_MACROS_SVH
`define HEADER_TEXT_TOKENIZER_MACROS_SVH
`ifndef ASSERT_OFF
`define HTT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HTT_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);
`else
`define HTT_ASSERT(lbl, prop, msg)
`define HTT_ASSERT_NEXT(lbl, trig, cond, msg)
`endif
`endif

FILE: rtl/htt_pkg.sv
package htt_pkg;

	// result queue depth
	localparam int RES_DEPTH = 4;

	// token kinds
	localparam logic [4:0] K_SPACE    = 5'd0;
	localparam logic [4:0] K_TAB      = 5'd1;
	localparam logic [4:0] K_CR       = 5'd2;
	localparam logic [4:0] K_CRLF     = 5'd3;
	localparam logic [4:0] K_LF       = 5'd4;
	localparam logic [4:0] K_COLON    = 5'd5;
	localparam logic [4:0] K_COMMA    = 5'd6;
	localparam logic [4:0] K_SLASH    = 5'd7;
	localparam logic [4:0] K_BSLASH   = 5'd8;
	localparam logic [4:0] K_LT       = 5'd9;
	localparam logic [4:0] K_GT       = 5'd10;
	localparam logic [4:0] K_TEXTCHAR = 5'd11;
	localparam logic [4:0] K_TEXTEND  = 5'd12;
	localparam logic [4:0] K_QCHAR    = 5'd13;
	localparam logic [4:0] K_QEND     = 5'd14;
	localparam logic [4:0] K_EOF      = 5'd15;
	localparam logic [4:0] K_ERROR    = 5'd16;

	// character codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_USCORE = 8'h5F;

	// request type codes
	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_EOS  = 1'b1;

	typedef enum logic [2:0] {
		M_IDLE,
		M_SPACE,
		M_CR,
		M_TEXT,
		M_QUOTE,
		M_DONE,
		M_ERROR
	} mode_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [4:0] token_kind;
		logic [7:0] token_byte;
		logic       last_result;
	} res_t;

	// results of one request, handed from lexer to queue
	typedef struct packed {
		logic [1:0] n_res;
		res_t       res0;
		res_t       res1;
	} lex_out_t;

endpackage

FILE: rtl/htt_lexer.sv
`include "header_text_tokenizer_macros.svh"

module htt_lexer (
	input  logic              clk,
	input  logic              arst_n,
	input  htt_pkg::req_t     item,
	input  logic              advance,
	output htt_pkg::lex_out_t lex
);

	typedef struct packed {
		logic            has;
		htt_pkg::res_t   res;
		htt_pkg::mode_t  mode;
	} sb_t;

	htt_pkg::mode_t mode_q, mode_d;
	logic           esc_q, esc_d;
	sb_t            sb;
	logic [7:0]     c;
	logic           eos;

	function automatic logic is_text(logic [7:0] ch);
		return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") ||
			(ch >= "0" && ch <= "9") || ch == htt_pkg::CH_DOT ||
			ch == htt_pkg::CH_DASH || ch == htt_pkg::CH_USCORE;
	endfunction

	function automatic htt_pkg::res_t mk(logic [4:0] kind, logic [7:0] ch);
		htt_pkg::res_t r;
		r.token_kind  = kind;
		r.token_byte  = ch;
		r.last_result = 1'b0;
		return r;
	endfunction

	// lex one byte from the idle mode
	function automatic sb_t start_byte(logic [7:0] ch);
		sb_t s;
		s.has  = 1'b1;
		s.res  = mk(htt_pkg::K_ERROR, 8'd0);
		s.mode = htt_pkg::M_IDLE;
		unique case (ch)
			htt_pkg::CH_SPACE: begin
				s.res  = mk(htt_pkg::K_SPACE, 8'd0);
				s.mode = htt_pkg::M_SPACE;
			end
			htt_pkg::CH_TAB:    s.res = mk(htt_pkg::K_TAB, 8'd0);
			htt_pkg::CH_CR: begin
				s.has  = 1'b0;
				s.mode = htt_pkg::M_CR;
			end
			htt_pkg::CH_LF:     s.res = mk(htt_pkg::K_LF, 8'd0);
			htt_pkg::CH_COLON:  s.res = mk(htt_pkg::K_COLON, 8'd0);
			htt_pkg::CH_COMMA:  s.res = mk(htt_pkg::K_COMMA, 8'd0);
			htt_pkg::CH_SLASH:  s.res = mk(htt_pkg::K_SLASH, 8'd0);
			htt_pkg::CH_BSLASH: s.res = mk(htt_pkg::K_BSLASH, 8'd0);
			htt_pkg::CH_LT:     s.res = mk(htt_pkg::K_LT, 8'd0);
			htt_pkg::CH_GT:     s.res = mk(htt_pkg::K_GT, 8'd0);
			htt_pkg::CH_QUOTE: begin
				s.has  = 1'b0;
				s.mode = htt_pkg::M_QUOTE;
			end
			default: begin
				if (is_text(ch)) begin
					s.res  = mk(htt_pkg::K_TEXTCHAR, ch);
					s.mode = htt_pkg::M_TEXT;
				end else begin
					s.mode = htt_pkg::M_ERROR;
				end
			end
		endcase
		return s;
	endfunction

	assign c   = item.data_byte;
	assign eos = (item.req_type == htt_pkg::REQ_EOS);

	always_comb begin
		sb        = start_byte(c);
		mode_d    = mode_q;
		esc_d     = esc_q;
		lex.n_res = 2'd0;
		lex.res0  = mk(htt_pkg::K_ERROR, 8'd0);
		lex.res1  = mk(htt_pkg::K_EOF, 8'd0);
		priority if (mode_q == htt_pkg::M_ERROR) begin
			lex.n_res = 2'd1;
		end else if (mode_q == htt_pkg::M_DONE) begin
			lex.n_res = 2'd1;
			lex.res0  = mk(htt_pkg::K_EOF, 8'd0);
		end else if (eos) begin
			esc_d = 1'b0;
			if (mode_q == htt_pkg::M_QUOTE) begin
				// unclosed quote
				lex.n_res = 2'd1;
				mode_d    = htt_pkg::M_ERROR;
			end else begin
				mode_d = htt_pkg::M_DONE;
				if (mode_q == htt_pkg::M_TEXT) begin
					lex.n_res = 2'd2;
					lex.res0  = mk(htt_pkg::K_TEXTEND, 8'd0);
				end else if (mode_q == htt_pkg::M_CR) begin
					lex.n_res = 2'd2;
					lex.res0  = mk(htt_pkg::K_CR, 8'd0);
				end else begin
					lex.n_res = 2'd1;
					lex.res0  = mk(htt_pkg::K_EOF, 8'd0);
				end
			end
		end else begin
			unique case (mode_q)
				htt_pkg::M_QUOTE: begin
					lex.n_res = 2'd1;
					lex.res0  = mk(htt_pkg::K_QCHAR, c);
					if (esc_q) begin
						esc_d = 1'b0;
					end else if (c == htt_pkg::CH_BSLASH) begin
						esc_d = 1'b1;
					end else if (c == htt_pkg::CH_QUOTE) begin
						lex.res0 = mk(htt_pkg::K_QEND, 8'd0);
						mode_d   = htt_pkg::M_IDLE;
					end
				end
				htt_pkg::M_SPACE: begin
					if (c != htt_pkg::CH_SPACE) begin
						lex.n_res = {1'b0, sb.has};
						lex.res0  = sb.res;
						mode_d    = sb.mode;
					end
				end
				htt_pkg::M_CR: begin
					if (c == htt_pkg::CH_LF) begin
						lex.n_res = 2'd1;
						lex.res0  = mk(htt_pkg::K_CRLF, 8'd0);
						mode_d    = htt_pkg::M_IDLE;
					end else begin
						lex.n_res = sb.has ? 2'd2 : 2'd1;
						lex.res0  = mk(htt_pkg::K_CR, 8'd0);
						lex.res1  = sb.res;
						mode_d    = sb.mode;
					end
				end
				htt_pkg::M_TEXT: begin
					if (is_text(c)) begin
						lex.n_res = 2'd1;
						lex.res0  = mk(htt_pkg::K_TEXTCHAR, c);
					end else begin
						lex.n_res = sb.has ? 2'd2 : 2'd1;
						lex.res0  = mk(htt_pkg::K_TEXTEND, 8'd0);
						lex.res1  = sb.res;
						mode_d    = sb.mode;
					end
				end
				default: begin
					lex.n_res = {1'b0, sb.has};
					lex.res0  = sb.res;
					mode_d    = sb.mode;
				end
			endcase
			if (mode_q != htt_pkg::M_QUOTE && mode_d == htt_pkg::M_QUOTE) begin
				esc_d = 1'b0;
			end
		end
		// flag the final result of the request
		if (lex.n_res == 2'd1) begin
			lex.res0.last_result = 1'b1;
		end
		if (lex.n_res == 2'd2) begin
			lex.res1.last_result = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= htt_pkg::M_IDLE;
			esc_q  <= 1'b0;
		end else if (advance) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
		end
	end

	`HTT_ASSERT_NEXT(a_done_sticky, mode_q == htt_pkg::M_DONE, mode_q == htt_pkg::M_DONE, "left eof state")
	`HTT_ASSERT_NEXT(a_error_sticky, mode_q == htt_pkg::M_ERROR, mode_q == htt_pkg::M_ERROR, "left error state")
	`HTT_ASSERT(a_esc_in_quote, esc_q |-> (mode_q == htt_pkg::M_QUOTE), "escape pending outside quotes")

endmodule

FILE: rtl/htt_res_fifo.sv
module htt_res_fifo #(
	parameter int DEPTH = htt_pkg::RES_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  htt_pkg::lex_out_t wr,
	output logic              fits,
	output logic              res_valid,
	input  logic              res_stall,
	output htt_pkg::res_t     res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	htt_pkg::res_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [1:0]    push_n;

	function automatic logic [AW-1:0] inc(logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr_p1 = inc(wr_ptr_q);
	assign push_n    = push ? wr.n_res : 2'd0;
	assign fits      = (int'(count_q) + int'(wr.n_res)) <= DEPTH;
	assign res_valid = (count_q != '0);
	assign pop       = res_valid && !res_stall;
	assign res       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= wr.res0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_p1] <= wr.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wr_ptr_q <= wr_ptr_p1;
			end else if (push_n == 2'd2) begin
				wr_ptr_q <= inc(wr_ptr_p1);
			end
			if (pop) begin
				rd_ptr_q <= inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push_n) - CW'(pop);
		end
	end

endmodule

FILE: rtl/header_text_tokenizer.sv
// channel   | valid      | stall      | payload
// request   | req_valid  | req_stall  | req (req_type, data_byte)
// result    | res_valid  | res_stall  | res (token_kind, token_byte, last_result)
//
// one request a cycle while the queue has room; each gives zero, one or two results
// path: request register, then the result queue, whose head drives res; a second
// result of one request leaves the queue after the first
// unless res_stall, the queue drains one result a cycle; two-result runs stall req
// req_stall rises only when the queue lacks room for the registered request's results
// reset clears the request valid, lexer mode, escape flag and queue pointers

module header_text_tokenizer #(
	parameter int RES_DEPTH = htt_pkg::RES_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  htt_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_stall,
	output htt_pkg::res_t res
);

	// request register
	logic              valid_s1;
	htt_pkg::req_t     req_s1;

	// lexer results for the registered request
	htt_pkg::lex_out_t lex;
	logic              fits;
	logic              advance;

	// the registered request moves on once the queue has room for its results
	assign advance   = valid_s1 && fits;
	assign req_stall = valid_s1 && !fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	htt_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (req_s1),
		.advance (advance),
		.lex     (lex)
	);

	htt_res_fifo #(
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.wr        (lex),
		.fits      (fits),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

FILE: verif/tb_header_text_tokenizer.sv
`timescale 1ns / 1ps

module tb_header_text_tokenizer;

	// cycle budget for the whole run, far above the slowest legal run
	localparam int LIMIT     = 200000;
	// long receiver hold-off that lets the result queue fill and stall requests
	localparam int HOLD      = 400;
	// cycles to watch for stray results once nothing is due
	localparam int DRAIN     = 20;
	// request counts at which the random part turns calm, then ends
	localparam int CALM_AT   = 450;
	localparam int RANDOM_TO = 530;

	// bytes with a meaning of their own outside quotes
	localparam logic [7:0] MARKS [10] = '{htt_pkg::CH_SPACE, htt_pkg::CH_TAB,
		htt_pkg::CH_CR, htt_pkg::CH_LF, htt_pkg::CH_COLON, htt_pkg::CH_COMMA,
		htt_pkg::CH_SLASH, htt_pkg::CH_BSLASH, htt_pkg::CH_LT, htt_pkg::CH_GT};

	// predictor of the lexer plus the queue of tokens still due
	class token_board;
		htt_pkg::mode_t lex;
		bit             esc;
		htt_pkg::res_t  tokens_due[$];
		htt_pkg::res_t  batch[$];
		int             fails;

		function new();
			lex   = htt_pkg::M_IDLE;
			esc   = 1'b0;
			fails = 0;
		endfunction

		static function bit is_text(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
				(c >= "0" && c <= "9") || c == htt_pkg::CH_DOT ||
				c == htt_pkg::CH_DASH || c == htt_pkg::CH_USCORE;
		endfunction

		function void put(logic [4:0] kind, logic [7:0] b);
			htt_pkg::res_t t;
			t.token_kind  = kind;
			t.token_byte  = b;
			t.last_result = 1'b0;
			batch = {batch, t};
		endfunction

		// a byte lexed as if nothing were pending, at most one token
		function void lex_fresh(logic [7:0] c);
			lex = htt_pkg::M_IDLE;
			case (c)
				htt_pkg::CH_SPACE: begin
					put(htt_pkg::K_SPACE, 8'h00);
					lex = htt_pkg::M_SPACE;
				end
				htt_pkg::CH_TAB:    put(htt_pkg::K_TAB, 8'h00);
				htt_pkg::CH_CR:     lex = htt_pkg::M_CR;
				htt_pkg::CH_LF:     put(htt_pkg::K_LF, 8'h00);
				htt_pkg::CH_COLON:  put(htt_pkg::K_COLON, 8'h00);
				htt_pkg::CH_COMMA:  put(htt_pkg::K_COMMA, 8'h00);
				htt_pkg::CH_SLASH:  put(htt_pkg::K_SLASH, 8'h00);
				htt_pkg::CH_BSLASH: put(htt_pkg::K_BSLASH, 8'h00);
				htt_pkg::CH_LT:     put(htt_pkg::K_LT, 8'h00);
				htt_pkg::CH_GT:     put(htt_pkg::K_GT, 8'h00);
				htt_pkg::CH_QUOTE: begin
					lex = htt_pkg::M_QUOTE;
					esc = 1'b0;
				end
				default: begin
					if (is_text(c)) begin
						put(htt_pkg::K_TEXTCHAR, c);
						lex = htt_pkg::M_TEXT;
					end else begin
						put(htt_pkg::K_ERROR, 8'h00);
						lex = htt_pkg::M_ERROR;
					end
				end
			endcase
		endfunction

		// accepted request: work out the tokens it gives
		function void take_request(htt_pkg::req_t r);
			logic [7:0] c;
			c = r.data_byte;
			batch.delete();
			if (lex == htt_pkg::M_ERROR) begin
				put(htt_pkg::K_ERROR, 8'h00);
			end else if (lex == htt_pkg::M_DONE) begin
				put(htt_pkg::K_EOF, 8'h00);
			end else if (r.req_type == htt_pkg::REQ_EOS) begin
				if (lex == htt_pkg::M_QUOTE) begin
					put(htt_pkg::K_ERROR, 8'h00);
					lex = htt_pkg::M_ERROR;
				end else begin
					if (lex == htt_pkg::M_TEXT)
						put(htt_pkg::K_TEXTEND, 8'h00);
					else if (lex == htt_pkg::M_CR)
						put(htt_pkg::K_CR, 8'h00);
					put(htt_pkg::K_EOF, 8'h00);
					lex = htt_pkg::M_DONE;
				end
				esc = 1'b0;
			end else begin
				case (lex)
					htt_pkg::M_QUOTE: begin
						if (esc) begin
							put(htt_pkg::K_QCHAR, c);
							esc = 1'b0;
						end else if (c == htt_pkg::CH_BSLASH) begin
							put(htt_pkg::K_QCHAR, c);
							esc = 1'b1;
						end else if (c == htt_pkg::CH_QUOTE) begin
							put(htt_pkg::K_QEND, 8'h00);
							lex = htt_pkg::M_IDLE;
						end else begin
							put(htt_pkg::K_QCHAR, c);
						end
					end
					htt_pkg::M_SPACE: begin
						if (c != htt_pkg::CH_SPACE)
							lex_fresh(c);
					end
					htt_pkg::M_CR: begin
						if (c == htt_pkg::CH_LF) begin
							put(htt_pkg::K_CRLF, 8'h00);
							lex = htt_pkg::M_IDLE;
						end else begin
							put(htt_pkg::K_CR, 8'h00);
							lex_fresh(c);
						end
					end
					htt_pkg::M_TEXT: begin
						if (is_text(c)) begin
							put(htt_pkg::K_TEXTCHAR, c);
						end else begin
							put(htt_pkg::K_TEXTEND, 8'h00);
							lex_fresh(c);
						end
					end
					default: lex_fresh(c);
				endcase
			end
			if (batch.size() > 0)
				batch[batch.size() - 1].last_result = 1'b1;
			tokens_due = {tokens_due, batch};
		endfunction

		// accepted result against the oldest token due
		function void match_token(htt_pkg::res_t got);
			htt_pkg::res_t want;
			if (tokens_due.size() == 0) begin
				$error("result with nothing due: token_kind %0d token_byte %0h",
					got.token_kind, got.token_byte);
				fails++;
				return;
			end
			want = tokens_due.pop_front();
			if (got.token_kind !== want.token_kind) begin
				$error("token_kind: expected %0d, actual %0d", want.token_kind, got.token_kind);
				fails++;
			end
			if (got.token_byte !== want.token_byte) begin
				$error("token_byte: expected %0h, actual %0h", want.token_byte, got.token_byte);
				fails++;
			end
			if (got.last_result !== want.last_result) begin
				$error("last_result: expected %0d, actual %0d",
					want.last_result, got.last_result);
				fails++;
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	htt_pkg::req_t req;
	logic          res_valid;
	logic          res_stall;
	htt_pkg::res_t res;

	token_board board = new();
	int  sent;
	int  cycle_count;
	// calm: no idling on either side; squeeze: ask for the long hold-off
	bit  calm;
	bit  squeeze;

	header_text_tokenizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// both channels are sampled at the edge, before any update it causes
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				board.take_request(req);
			if (res_valid && !res_stall)
				board.match_token(res);
		end
	end

	// watchdog: a run past the budget counts as a failure
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	function automatic logic [7:0] pick_text();
		int r;
		r = $urandom_range(0, 64);
		if (r < 26)
			return 8'(r) + "a";
		else if (r < 52)
			return 8'(r - 26) + "A";
		else if (r < 62)
			return 8'(r - 52) + "0";
		else if (r == 62)
			return htt_pkg::CH_DOT;
		else if (r == 63)
			return htt_pkg::CH_DASH;
		return htt_pkg::CH_USCORE;
	endfunction

	// any byte that leaves the lexer out of error, quote excluded
	function automatic logic [7:0] pick_known();
		if ($urandom_range(0, 3) == 0)
			return pick_text();
		return MARKS[4'($urandom_range(0, 9))];
	endfunction

	function automatic bit is_known(logic [7:0] c);
		bit hit;
		hit = token_board::is_text(c) || c == htt_pkg::CH_QUOTE;
		foreach (MARKS[i])
			if (MARKS[i] == c)
				hit = 1'b1;
		return hit;
	endfunction

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// offer one request and hold it until taken, then maybe pause
	task automatic send_req(input logic kind, input logic [7:0] b);
		req       <= {kind, b};
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		sent++;
		if (!calm && !squeeze && $urandom_range(0, 6) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// receiver: random stall bursts, plus the one long hold-off
	initial begin
		res_stall = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (squeeze) begin
				res_stall <= 1'b1;
				repeat (HOLD) @(posedge clk);
				squeeze = 1'b0;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				res_stall <= 1'b0;
				repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 120 : 24))
					@(posedge clk);
			end
		end
	end

	initial begin
		int         n;
		logic [7:0] b;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		calm      = 1'b0;
		squeeze   = 1'b0;
		sent      = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: text range ends, space run, tab, crlf, lone cr, lf, punctuation
		send_req(htt_pkg::REQ_DATA, "A");
		send_req(htt_pkg::REQ_DATA, "z");
		send_req(htt_pkg::REQ_DATA, "0");
		send_req(htt_pkg::REQ_DATA, "9");
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_DOT);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_DASH);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_USCORE);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_SPACE);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_SPACE);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_TAB);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_CR);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_LF);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_CR);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_COLON);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_LF);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_COMMA);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_SLASH);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_BSLASH);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_LT);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_GT);
		// quoted: byte extremes, escaped quote, escaped backslash, then the close
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_QUOTE);
		send_req(htt_pkg::REQ_DATA, 8'h00);
		send_req(htt_pkg::REQ_DATA, 8'hFF);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_BSLASH);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_QUOTE);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_BSLASH);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_BSLASH);
		send_req(htt_pkg::REQ_DATA, htt_pkg::CH_QUOTE);

		// random header-like stream; the long hold-off lands at its start
		squeeze = 1'b1;
		while (sent < RANDOM_TO) begin
			if (sent >= CALM_AT)
				calm = 1'b1;
			case ($urandom_range(0, 10))
				0, 1: begin
					repeat ($urandom_range(1, 8)) send_req(htt_pkg::REQ_DATA, pick_text());
				end
				2: repeat ($urandom_range(1, 4)) send_req(htt_pkg::REQ_DATA, htt_pkg::CH_SPACE);
				3: send_req(htt_pkg::REQ_DATA, htt_pkg::CH_TAB);
				4: begin
					send_req(htt_pkg::REQ_DATA, htt_pkg::CH_CR);
					send_req(htt_pkg::REQ_DATA, htt_pkg::CH_LF);
				end
				5: send_req(htt_pkg::REQ_DATA, htt_pkg::CH_CR);
				6: send_req(htt_pkg::REQ_DATA, MARKS[4'($urandom_range(3, 9))]);
				7, 8: begin
					send_req(htt_pkg::REQ_DATA, htt_pkg::CH_QUOTE);
					n = $urandom_range(0, 10);
					repeat (n) begin
						if ($urandom_range(0, 5) == 0) begin
							send_req(htt_pkg::REQ_DATA, htt_pkg::CH_BSLASH);
							send_req(htt_pkg::REQ_DATA, any_byte());
						end else begin
							do
								b = any_byte();
							while (b == htt_pkg::CH_QUOTE || b == htt_pkg::CH_BSLASH);
							send_req(htt_pkg::REQ_DATA, b);
						end
					end
					send_req(htt_pkg::REQ_DATA, htt_pkg::CH_QUOTE);
				end
				default: repeat ($urandom_range(1, 6)) send_req(htt_pkg::REQ_DATA, pick_known());
			endcase
		end

		// one way out of the stream, since eof and error both stick
		case ($urandom_range(0, 4))
			0: begin
				repeat ($urandom_range(1, 3)) send_req(htt_pkg::REQ_DATA, pick_text());
				send_req(htt_pkg::REQ_EOS, any_byte());
			end
			1: begin
				send_req(htt_pkg::REQ_DATA, htt_pkg::CH_CR);
				send_req(htt_pkg::REQ_EOS, any_byte());
			end
			2: begin
				send_req(htt_pkg::REQ_DATA, htt_pkg::CH_SPACE);
				send_req(htt_pkg::REQ_EOS, any_byte());
			end
			3: begin
				// quote left open at end of stream
				send_req(htt_pkg::REQ_DATA, htt_pkg::CH_QUOTE);
				repeat ($urandom_range(0, 4)) send_req(htt_pkg::REQ_DATA, pick_known());
				if ($urandom_range(0, 1) == 0)
					send_req(htt_pkg::REQ_DATA, htt_pkg::CH_BSLASH);
				send_req(htt_pkg::REQ_EOS, any_byte());
			end
			default: begin
				// unknown byte, sometimes closing a text run first
				if ($urandom_range(0, 1) == 0)
					send_req(htt_pkg::REQ_DATA, pick_text());
				if ($urandom_range(0, 1) == 0)
					b = 8'($urandom_range(128, 255));
				else
					do
						b = 8'($urandom_range(0, 127));
					while (is_known(b));
				send_req(htt_pkg::REQ_DATA, b);
			end
		endcase
		// sticky behaviour: everything after gives the same token
		repeat (10) begin
			if ($urandom_range(0, 2) == 0)
				send_req(htt_pkg::REQ_EOS, any_byte());
			else
				send_req(htt_pkg::REQ_DATA, any_byte());
		end
		req_valid <= 1'b0;

		while (board.tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (board.fails == 0 && board.tokens_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
